@@ rtl/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg
// Shared widths, codes and controller/datapath interface types for the
// betweenness centrality engine.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int unsigned MAX_VERTICES_DEF     = 4096;
  localparam int unsigned MAX_EDGES_DEF        = 65536;
  localparam int unsigned MAX_PREDECESSORS_DEF = 32;

  localparam int unsigned OPC_W     = 2;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned VALUE_W   = 17;
  localparam int unsigned NV_W      = 13;
  localparam int unsigned NE_W      = 17;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned VERTEX_W  = 12;
  localparam int unsigned SCORE_W   = 40;
  localparam int unsigned SIGMA_W   = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DCNT_W    = $clog2(FRAC_W);

  typedef enum logic [OPC_W-1:0] {
    OP_WR_OFFSET    = 2'd0,
    OP_WR_NEIGHBOUR = 2'd1,
    OP_RUN          = 2'd2,
    OP_READ         = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_EDGES    = 1'd1;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_SCORE = 1'b1;

  typedef enum logic [23:0] {
    ST_IDLE       = 24'h000001,
    ST_READ       = 24'h000002,
    ST_CLR        = 24'h000004,
    ST_SRC_INIT   = 24'h000008,
    ST_SRC_SEED   = 24'h000010,
    ST_BFS_HEAD   = 24'h000020,
    ST_BFS_V      = 24'h000040,
    ST_BFS_RS0    = 24'h000080,
    ST_BFS_RS1    = 24'h000100,
    ST_BFS_EDGE   = 24'h000200,
    ST_BFS_NB     = 24'h000400,
    ST_BFS_W      = 24'h000800,
    ST_REV_POP    = 24'h001000,
    ST_REV_W      = 24'h002000,
    ST_REV_WD     = 24'h004000,
    ST_REV_PRED   = 24'h008000,
    ST_REV_V      = 24'h010000,
    ST_REV_DIVSET = 24'h020000,
    ST_REV_DIV    = 24'h040000,
    ST_REV_MUL0   = 24'h080000,
    ST_REV_MUL1   = 24'h100000,
    ST_REV_ACC    = 24'h200000,
    ST_REV_UPD    = 24'h400000,
    ST_DONE       = 24'h800000
  } state_t;

  typedef struct packed {
    state_t phase;
    logic   accept;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic init_last;
    logic n_zero;
    logic src_last;
    logic head_lt_tail;
    logic edge_more;
    logic w_out;
    logic tail_zero;
    logic pred_more;
    logic div_trivial;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/bce_ctrl.sv @@
// ----------------------------------------------------------------------------
// bce_ctrl
// Sequencer for load, read and run transactions: walks the score clear,
// per-source init, breadth-first pass and reverse accumulation.
// ----------------------------------------------------------------------------
module bce_ctrl import bce_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [OPC_W-1:0] in_opcode,
  output logic             in_stall,
  input  sts_t             sts,
  output cmd_t             cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall   = (state_r != ST_IDLE) || !sts.out_free;
  assign accept     = in_valid && !in_stall;
  assign cmd.phase  = state_r;
  assign cmd.accept = accept;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_t'(in_opcode) == OP_RUN) state_nxt = ST_CLR;
          else if (opcode_t'(in_opcode) == OP_READ) state_nxt = ST_READ;
        end
      end
      ST_READ:       if (sts.out_free) state_nxt = ST_IDLE;
      ST_CLR:        if (sts.clr_last) state_nxt = sts.n_zero ? ST_DONE : ST_SRC_INIT;
      ST_SRC_INIT:   if (sts.init_last) state_nxt = ST_SRC_SEED;
      ST_SRC_SEED:   state_nxt = ST_BFS_HEAD;
      ST_BFS_HEAD:   state_nxt = sts.head_lt_tail ? ST_BFS_V : ST_REV_POP;
      ST_BFS_V:      state_nxt = ST_BFS_RS0;
      ST_BFS_RS0:    state_nxt = ST_BFS_RS1;
      ST_BFS_RS1:    state_nxt = ST_BFS_EDGE;
      ST_BFS_EDGE:   state_nxt = sts.edge_more ? ST_BFS_NB : ST_BFS_HEAD;
      ST_BFS_NB:     state_nxt = sts.w_out ? ST_BFS_EDGE : ST_BFS_W;
      ST_BFS_W:      state_nxt = ST_BFS_EDGE;
      ST_REV_POP: begin
        if (!sts.tail_zero) state_nxt = ST_REV_W;
        else state_nxt = sts.src_last ? ST_DONE : ST_SRC_INIT;
      end
      ST_REV_W:      state_nxt = ST_REV_WD;
      ST_REV_WD:     state_nxt = ST_REV_PRED;
      ST_REV_PRED:   state_nxt = sts.pred_more ? ST_REV_V : ST_REV_POP;
      ST_REV_V:      state_nxt = ST_REV_DIVSET;
      ST_REV_DIVSET: state_nxt = sts.div_trivial ? ST_REV_MUL0 : ST_REV_DIV;
      ST_REV_DIV:    if (sts.div_last) state_nxt = ST_REV_MUL0;
      ST_REV_MUL0:   state_nxt = ST_REV_MUL1;
      ST_REV_MUL1:   state_nxt = ST_REV_ACC;
      ST_REV_ACC:    state_nxt = ST_REV_UPD;
      ST_REV_UPD:    state_nxt = ST_REV_PRED;
      ST_DONE:       if (sts.out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/bce_dp.sv @@
// ----------------------------------------------------------------------------
// bce_dp
// Datapath: graph, score and per-source working memories, counters,
// bit-serial divider, split multiplier and the result register.
// ----------------------------------------------------------------------------
module bce_dp import bce_pkg::*; #(
  parameter int unsigned MAX_VERTICES     = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES        = MAX_EDGES_DEF,
  parameter int unsigned MAX_PREDECESSORS = MAX_PREDECESSORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [OPC_W-1:0]     in_opcode,
  input  logic [INDEX_W-1:0]   in_index,
  input  logic [VALUE_W-1:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [VERTEX_W-1:0]  out_vertex,
  output logic [SCORE_W-1:0]   out_score,
  output logic                 out_overflow,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int unsigned VW     = $clog2(MAX_VERTICES);
  localparam int unsigned VCW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW    = $clog2(MAX_EDGES + 1);
  localparam int unsigned CW     = (ECW > VALUE_W) ? ECW : VALUE_W;
  localparam int unsigned PD     = MAX_VERTICES * MAX_PREDECESSORS;
  localparam int unsigned PAW    = $clog2(PD);
  localparam int unsigned PCW    = $clog2(MAX_PREDECESSORS + 1);
  localparam int unsigned XW     = SCORE_W + 1;
  localparam int unsigned LO_W   = 21;
  localparam int unsigned HI_W   = XW - LO_W;
  localparam int unsigned PLO_W  = FRAC_W + LO_W;
  localparam int unsigned PHI_W  = FRAC_W + HI_W;
  localparam int unsigned FULL_W = PHI_W + LO_W + 1;
  localparam int unsigned TERM_W = FULL_W - FRAC_W;
  localparam int unsigned QW     = FRAC_W + 1;

  localparam logic [XW-1:0]      ONE_X     = XW'(1) << FRAC_W;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [SIGMA_W-1:0] SIGMA_MAX = {SIGMA_W{1'b1}};

  // memories
  logic [VALUE_W-1:0] rs_mem    [MAX_VERTICES+1];
  logic [VALUE_W-1:0] nb_mem    [MAX_EDGES];
  logic [SCORE_W-1:0] score_mem [MAX_VERTICES];
  logic [SIGMA_W-1:0] sigma_mem [MAX_VERTICES];
  logic [VCW-1:0]     dist_mem  [MAX_VERTICES];
  logic               vis_mem   [MAX_VERTICES];
  logic [VW-1:0]      order_mem [MAX_VERTICES];
  logic [VW-1:0]      pred_mem  [PD];
  logic [PCW-1:0]     pc_mem    [MAX_VERTICES];
  logic [SCORE_W-1:0] delta_mem [MAX_VERTICES];

  logic               rs_we, nb_we, score_we, sigma_we, dist_we, vis_we;
  logic               order_we, pred_we, pc_we, delta_we;
  logic [VCW-1:0]     rs_wa, rs_ra;
  logic [EAW-1:0]     nb_wa, nb_ra;
  logic [VW-1:0]      score_wa, score_ra, sigma_wa, sigma_ra, dist_wa, dist_ra;
  logic [VW-1:0]      vis_wa, vis_ra, order_wa, order_ra, pc_wa, pc_ra;
  logic [VW-1:0]      delta_wa, delta_ra;
  logic [PAW-1:0]     pred_wa, pred_ra;
  logic [SCORE_W-1:0] score_wd, delta_wd;
  logic [SIGMA_W-1:0] sigma_wd;
  logic [VCW-1:0]     dist_wd;
  logic               vis_wd;
  logic [VW-1:0]      order_wd;
  logic [PCW-1:0]     pc_wd;

  logic [VALUE_W-1:0] rs_q, nb_q;
  logic [SCORE_W-1:0] score_q, delta_q;
  logic [SIGMA_W-1:0] sigma_q;
  logic [VCW-1:0]     dist_q;
  logic               vis_q;
  logic [VW-1:0]      order_q, pred_q;
  logic [PCW-1:0]     pc_q;

  // configuration and control registers
  logic [NV_W-1:0]    num_vertices_r;
  logic [NE_W-1:0]    num_edges_r;
  logic               ovf_r, ovf_nxt;
  logic               scores_valid_r;
  logic               out_valid_r, out_valid_nxt;

  // working registers
  logic [VW-1:0]      i_r, s_r, v_r, w_r;
  logic [VCW-1:0]     head_r, tail_r, nd_r;
  logic [CW-1:0]      e_r, end_r;
  logic [SIGMA_W-1:0] sv_r, sw_r, rem_r;
  logic [SCORE_W-1:0] dw_r, dv_r;
  logic [PCW-1:0]     pcw_r, k_r;
  logic [QW-1:0]      q_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [PLO_W-1:0]   plo_r;
  logic [PHI_W-1:0]   phi_r;
  logic [TERM_W-1:0]  term_r;
  logic [INDEX_W-1:0] rd_idx_r;
  logic               rd_in_r;
  logic               out_kind_r, out_overflow_r;
  logic [VERTEX_W-1:0] out_vertex_r;
  logic [SCORE_W-1:0] out_score_r;

  // derived values
  logic [VALUE_W-1:0] nv_x, maxv_x, n_x;
  logic [VCW-1:0]     n_used;
  logic [CW-1:0]      ne_x, rs_x;
  logic               accept, out_free, load_read, load_done;
  logic               rs_ok, nb_ok;
  logic               w_eq;
  logic [SIGMA_W:0]   sigma_sum;
  logic               pc_room;
  logic [SCORE_W:0]   score_sum;
  logic [SIGMA_W:0]   rem2;
  logic               div_ge;
  logic [XW-1:0]      xw;
  logic [PLO_W-1:0]   plo;
  logic [PHI_W-1:0]   phi;
  logic [FULL_W-1:0]  full;
  logic [TERM_W:0]    upd_sum;

  assign nv_x   = VALUE_W'(num_vertices_r);
  assign maxv_x = VALUE_W'(MAX_VERTICES);
  assign n_x    = (nv_x < maxv_x) ? nv_x : maxv_x;
  assign n_used = VCW'(n_x);
  assign ne_x   = (CW'(num_edges_r) < CW'(MAX_EDGES)) ? CW'(num_edges_r) : CW'(MAX_EDGES);
  assign rs_x   = CW'(rs_q);

  assign accept    = cmd.accept;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_read = (cmd.phase == ST_READ) && out_free;
  assign load_done = (cmd.phase == ST_DONE) && out_free;
  assign rs_ok     = 32'(in_index) <= 32'(MAX_VERTICES);
  assign nb_ok     = 32'(in_index) < 32'(MAX_EDGES);

  assign w_eq      = !vis_q || (dist_q == nd_r);
  assign sigma_sum = {1'b0, sigma_q} + {1'b0, sv_r};
  assign pc_room   = pc_q < PCW'(MAX_PREDECESSORS);
  assign score_sum = {1'b0, score_q} + {1'b0, delta_q};
  assign rem2      = {rem_r, 1'b0};
  assign div_ge    = rem2 >= {1'b0, sw_r};
  assign xw        = ONE_X + XW'(dw_r);
  assign plo       = q_r[FRAC_W-1:0] * xw[LO_W-1:0];
  assign phi       = q_r[FRAC_W-1:0] * xw[XW-1:LO_W];
  assign full      = {1'b0, phi_r, {LO_W{1'b0}}} + FULL_W'(plo_r);
  assign upd_sum   = (TERM_W+1)'(dv_r) + (TERM_W+1)'(term_r);

  assign sts.clr_last     = i_r == VW'(MAX_VERTICES - 1);
  assign sts.init_last    = (VCW'(i_r) + VCW'(1)) == n_used;
  assign sts.n_zero       = n_used == '0;
  assign sts.src_last     = (VCW'(s_r) + VCW'(1)) == n_used;
  assign sts.head_lt_tail = head_r < tail_r;
  assign sts.edge_more    = e_r < end_r;
  assign sts.w_out        = nb_q >= VALUE_W'(n_used);
  assign sts.tail_zero    = tail_r == '0;
  assign sts.pred_more    = k_r < pcw_r;
  assign sts.div_trivial  = (sw_r == '0) || (sigma_q >= sw_r);
  assign sts.div_last     = dcnt_r == DCNT_W'(FRAC_W - 1);
  assign sts.out_free     = out_free;

  // memory port steering
  always_comb begin
    rs_we = 1'b0; nb_we = 1'b0; score_we = 1'b0; sigma_we = 1'b0; dist_we = 1'b0;
    vis_we = 1'b0; order_we = 1'b0; pred_we = 1'b0; pc_we = 1'b0; delta_we = 1'b0;
    rs_wa = VCW'(in_index); rs_ra = '0;
    nb_wa = EAW'(in_index); nb_ra = '0;
    score_wa = i_r; score_ra = VW'(in_index); score_wd = '0;
    sigma_wa = i_r; sigma_ra = '0; sigma_wd = '0;
    dist_wa = i_r; dist_ra = '0; dist_wd = '0;
    vis_wa = i_r; vis_ra = '0; vis_wd = 1'b0;
    order_wa = '0; order_ra = '0; order_wd = s_r;
    pred_wa = PAW'(w_r) * PAW'(MAX_PREDECESSORS) + PAW'(pc_q);
    pred_ra = PAW'(w_r) * PAW'(MAX_PREDECESSORS) + PAW'(k_r);
    pc_wa = i_r; pc_ra = '0; pc_wd = '0;
    delta_wa = i_r; delta_ra = '0; delta_wd = '0;
    unique case (cmd.phase)
      ST_IDLE: begin
        if (accept && opcode_t'(in_opcode) == OP_WR_OFFSET && rs_ok) rs_we = 1'b1;
        if (accept && opcode_t'(in_opcode) == OP_WR_NEIGHBOUR && nb_ok) nb_we = 1'b1;
      end
      ST_CLR: score_we = 1'b1;
      ST_SRC_INIT: begin
        vis_we = 1'b1; dist_we = 1'b1; sigma_we = 1'b1; pc_we = 1'b1; delta_we = 1'b1;
      end
      ST_SRC_SEED: begin
        vis_we = 1'b1; vis_wa = s_r; vis_wd = 1'b1;
        sigma_we = 1'b1; sigma_wa = s_r; sigma_wd = SIGMA_W'(1);
        order_we = 1'b1;
      end
      ST_BFS_HEAD: order_ra = VW'(head_r);
      ST_BFS_V: begin
        rs_ra = VCW'(order_q); dist_ra = order_q; sigma_ra = order_q;
      end
      ST_BFS_RS0: rs_ra = VCW'(v_r) + VCW'(1);
      ST_BFS_EDGE: nb_ra = EAW'(e_r);
      ST_BFS_NB: begin
        vis_ra = VW'(nb_q); dist_ra = VW'(nb_q); sigma_ra = VW'(nb_q); pc_ra = VW'(nb_q);
      end
      ST_BFS_W: begin
        if (!vis_q) begin
          vis_we = 1'b1; vis_wa = w_r; vis_wd = 1'b1;
          dist_we = 1'b1; dist_wa = w_r; dist_wd = nd_r;
          order_we = 1'b1; order_wa = VW'(tail_r); order_wd = w_r;
        end
        if (w_eq) begin
          sigma_we = 1'b1; sigma_wa = w_r;
          sigma_wd = sigma_sum[SIGMA_W] ? SIGMA_MAX : sigma_sum[SIGMA_W-1:0];
          if (pc_room) begin
            pred_we = 1'b1;
            pc_we = 1'b1; pc_wa = w_r; pc_wd = pc_q + PCW'(1);
          end
        end
      end
      ST_REV_POP: order_ra = VW'(tail_r - VCW'(1));
      ST_REV_W: begin
        delta_ra = order_q; sigma_ra = order_q; pc_ra = order_q; score_ra = order_q;
      end
      ST_REV_WD: begin
        score_we = w_r != s_r; score_wa = w_r;
        score_wd = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
      end
      ST_REV_V: begin
        sigma_ra = pred_q; delta_ra = pred_q;
      end
      ST_REV_UPD: begin
        delta_we = 1'b1; delta_wa = v_r;
        delta_wd = (upd_sum > (TERM_W+1)'(SCORE_MAX)) ? SCORE_MAX : upd_sum[SCORE_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_wa] <= in_value;
    rs_q <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (nb_we) nb_mem[nb_wa] <= in_value;
    nb_q <= nb_mem[nb_ra];
  end

  always_ff @(posedge clk) begin
    if (score_we) score_mem[score_wa] <= score_wd;
    score_q <= score_mem[score_ra];
  end

  always_ff @(posedge clk) begin
    if (sigma_we) sigma_mem[sigma_wa] <= sigma_wd;
    sigma_q <= sigma_mem[sigma_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (order_we) order_mem[order_wa] <= order_wd;
    order_q <= order_mem[order_ra];
  end

  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[pred_wa] <= v_r;
    pred_q <= pred_mem[pred_ra];
  end

  always_ff @(posedge clk) begin
    if (pc_we) pc_mem[pc_wa] <= pc_wd;
    pc_q <= pc_mem[pc_ra];
  end

  always_ff @(posedge clk) begin
    if (delta_we) delta_mem[delta_wa] <= delta_wd;
    delta_q <= delta_mem[delta_ra];
  end

  always_comb begin
    ovf_nxt = ovf_r;
    if (cmd.phase == ST_IDLE && accept && opcode_t'(in_opcode) == OP_RUN) ovf_nxt = 1'b0;
    else if (cmd.phase == ST_BFS_W && w_eq && (sigma_sum[SIGMA_W] || !pc_room)) ovf_nxt = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_read || load_done) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vertices_r <= '0;
      num_edges_r    <= '0;
      ovf_r          <= 1'b0;
      scores_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wen && cfg_index == REG_NUM_VERTICES) num_vertices_r <= cfg_wdata[NV_W-1:0];
      if (cfg_wen && cfg_index == REG_NUM_EDGES) num_edges_r <= cfg_wdata[NE_W-1:0];
      if (cmd.phase == ST_IDLE && accept && opcode_t'(in_opcode) == OP_RUN) begin
        scores_valid_r <= 1'b1;
      end
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    unique case (cmd.phase)
      ST_IDLE: begin
        i_r      <= '0;
        s_r      <= '0;
        rd_idx_r <= in_index;
        rd_in_r  <= 32'(in_index) < 32'(MAX_VERTICES);
      end
      ST_CLR: i_r <= sts.clr_last ? '0 : i_r + VW'(1);
      ST_SRC_INIT: i_r <= i_r + VW'(1);
      ST_SRC_SEED: begin
        head_r <= '0;
        tail_r <= VCW'(1);
      end
      ST_BFS_HEAD: if (sts.head_lt_tail) head_r <= head_r + VCW'(1);
      ST_BFS_V: v_r <= order_q;
      ST_BFS_RS0: begin
        e_r  <= rs_x;
        nd_r <= dist_q + VCW'(1);
        sv_r <= sigma_q;
      end
      ST_BFS_RS1: end_r <= (rs_x < ne_x) ? rs_x : ne_x;
      ST_BFS_EDGE: if (sts.edge_more) e_r <= e_r + CW'(1);
      ST_BFS_NB: w_r <= VW'(nb_q);
      ST_BFS_W: if (!vis_q) tail_r <= tail_r + VCW'(1);
      ST_REV_POP: begin
        if (!sts.tail_zero) begin
          tail_r <= tail_r - VCW'(1);
        end else begin
          s_r <= s_r + VW'(1);
          i_r <= '0;
        end
      end
      ST_REV_W: w_r <= order_q;
      ST_REV_WD: begin
        dw_r  <= delta_q;
        sw_r  <= sigma_q;
        pcw_r <= pc_q;
        k_r   <= '0;
      end
      ST_REV_PRED: if (sts.pred_more) k_r <= k_r + PCW'(1);
      ST_REV_V: v_r <= pred_q;
      ST_REV_DIVSET: begin
        dv_r   <= delta_q;
        rem_r  <= sigma_q;
        dcnt_r <= '0;
        // zero path count gives zero; a ratio at or above one clamps to one
        if (sw_r == '0) q_r <= '0;
        else if (sigma_q >= sw_r) q_r <= QW'(1) << FRAC_W;
        else q_r <= '0;
      end
      ST_REV_DIV: begin
        rem_r  <= div_ge ? SIGMA_W'(rem2 - {1'b0, sw_r}) : rem2[SIGMA_W-1:0];
        q_r    <= {q_r[QW-2:0], div_ge};
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      ST_REV_MUL0: plo_r <= plo;
      ST_REV_MUL1: phi_r <= phi;
      ST_REV_ACC: term_r <= q_r[FRAC_W] ? TERM_W'(xw) : full[FULL_W-1:FRAC_W];
      default: ;
    endcase

    if (load_read) begin
      out_kind_r     <= KIND_SCORE;
      out_vertex_r   <= rd_idx_r[VERTEX_W-1:0];
      out_score_r    <= (rd_in_r && scores_valid_r) ? score_q : '0;
      out_overflow_r <= ovf_r;
    end else if (load_done) begin
      out_kind_r     <= KIND_DONE;
      out_vertex_r   <= '0;
      out_score_r    <= '0;
      out_overflow_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_vertex   = out_vertex_r;
  assign out_score    = out_score_r;
  assign out_overflow = out_overflow_r;

endmodule

@@ rtl/betweenness_centrality_engine_core.sv @@
// Offset and neighbour writes return nothing.
// A score read passes the READ state into the result register; input reopens back in idle.
// A run clears MAX_VERTICES score entries, then per source initializes n entries, runs the
// breadth-first pass and the reverse pass with a bit-serial divide and split multiply per
// predecessor; each memory has one read and one write port.
// Reset is synchronous; scores read zero until the first run, no clearing pass.
// ----------------------------------------------------------------------------
// betweenness_centrality_engine_core
// Brandes betweenness over a compressed-row graph with Q24.16 scores.
// ----------------------------------------------------------------------------
module betweenness_centrality_engine_core import bce_pkg::*; #(
  parameter int unsigned MAX_VERTICES     = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES        = MAX_EDGES_DEF,
  parameter int unsigned MAX_PREDECESSORS = MAX_PREDECESSORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OPC_W-1:0]     in_opcode,
  input  logic [INDEX_W-1:0]   in_index,
  input  logic [VALUE_W-1:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [VERTEX_W-1:0]  out_vertex,
  output logic [SCORE_W-1:0]   out_score,
  output logic                 out_overflow
);

  cmd_t cmd;
  sts_t sts;

  bce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bce_dp #(
    .MAX_VERTICES     (MAX_VERTICES),
    .MAX_EDGES        (MAX_EDGES),
    .MAX_PREDECESSORS (MAX_PREDECESSORS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_opcode    (in_opcode),
    .in_index     (in_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_vertex   (out_vertex),
    .out_score    (out_score),
    .out_overflow (out_overflow),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
